@@ rtl/text_console_writer_core_assert.svh @@
// Assertion macros used by the console writer checker.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TCW_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tcw_pkg.sv @@
// Shared types and constants of the text console writer.
package tcw_pkg;

    localparam int FUNC_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int OROW_W   = 5;
    localparam int OCOL_W   = 7;
    localparam int OFS_W    = 11;
    localparam int CELL_W   = 16;

    localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COLORS = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0]        CLEAR_ATTR   = 8'h07;

    typedef struct packed {
        logic [OROW_W-1:0] pos_row;
        logic [OCOL_W-1:0] pos_col;
        logic [OFS_W-1:0]  cursor_offset;
        logic [CHAR_W-1:0] cell_char;
        logic [7:0]        cell_attr;
    } res_t;

endpackage

@@ rtl/tcw_screen_ram.sv @@
// Screen cell memory: one write port, one registered read port.
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [tcw_pkg::CELL_W-1:0]  rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tcw_ctrl.sv @@
// Console sequencer: cursor state, shared pointer unit and memory sweeps.
module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int CELLS  = ROWS * COLUMNS,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tcw_pkg::FUNC_W-1:0]    s_func,
    input  logic [tcw_pkg::CHAR_W-1:0]    s_char_code,
    input  logic [tcw_pkg::COLOR_W-1:0]   s_fg_color,
    input  logic [tcw_pkg::COLOR_W-1:0]   s_bg_color,
    input  logic [tcw_pkg::RROW_W-1:0]    s_read_row,
    input  logic [tcw_pkg::RCOL_W-1:0]    s_read_col,
    input  logic                          out_free,
    output logic                          res_valid,
    output tcw_pkg::res_t                 res,
    output logic                          ram_we,
    output logic [ADDR_W-1:0]             ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0]    ram_wdata,
    output logic                          ram_re,
    output logic [ADDR_W-1:0]             ram_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]    ram_rdata
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int RW = (ROW_W > tcw_pkg::OROW_W) ? ROW_W : tcw_pkg::OROW_W;
    localparam int CW = (COL_W > tcw_pkg::OCOL_W) ? COL_W : tcw_pkg::OCOL_W;
    localparam int AW = (ADDR_W > tcw_pkg::OFS_W) ? ADDR_W : tcw_pkg::OFS_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COL_STEP      = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);

    localparam logic [3:0] ST_CLR_INIT = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_EXEC     = 4'd2;
    localparam logic [3:0] ST_SCROLL   = 4'd3;
    localparam logic [3:0] ST_SCR_END  = 4'd4;
    localparam logic [3:0] ST_FILL     = 4'd5;
    localparam logic [3:0] ST_RD_ISSUE = 4'd6;
    localparam logic [3:0] ST_RD_WAIT  = 4'd7;
    localparam logic [3:0] ST_FIN      = 4'd8;

    logic [3:0]                   state_reg, state_next;
    logic [ROW_W-1:0]             row_reg, row_next;
    logic [COL_W-1:0]             col_reg, col_next;
    logic [ADDR_W-1:0]            base_reg, base_next;
    logic [ADDR_W-1:0]            cur_reg, cur_next;
    logic [7:0]                   attr_reg, attr_next;
    logic [ADDR_W-1:0]            ptr_reg, ptr_next;
    logic                         cp_valid_reg, cp_valid_next;
    logic [ADDR_W-1:0]            cp_dst_reg, cp_dst_next;
    logic [ADDR_W-1:0]            rd_addr_reg, rd_addr_next;
    logic [tcw_pkg::CHAR_W-1:0]   cchar_reg, cchar_next;
    logic [7:0]                   cattr_reg, cattr_next;

    logic [tcw_pkg::FUNC_W-1:0]   func_reg;
    logic [tcw_pkg::CHAR_W-1:0]   char_reg;
    logic [tcw_pkg::COLOR_W-1:0]  fg_reg;
    logic [tcw_pkg::COLOR_W-1:0]  bg_reg;
    logic [tcw_pkg::RROW_W-1:0]   rrow_reg;
    logic [tcw_pkg::RCOL_W-1:0]   rcol_reg;

    // shared pointer unit: one incrementer and one end compare
    logic [ADDR_W-1:0] ptr_inc;
    logic              ptr_last;
    assign ptr_inc  = ptr_reg + 1'b1;
    assign ptr_last = (ptr_reg == LAST_ADDR);

    logic is_nl, do_nl, in_range;
    logic [ADDR_W-1:0] rd_addr_calc;
    assign is_nl    = (char_reg == tcw_pkg::NEWLINE_CODE);
    assign do_nl    = is_nl || (col_reg == LAST_COL);
    assign in_range = (32'(rrow_reg) < ROWS) && (32'(rcol_reg) < COLUMNS);
    assign rd_addr_calc = ADDR_W'(32'(rrow_reg) * COLUMNS + 32'(rcol_reg));

    logic [RW-1:0] row_wide;
    logic [CW-1:0] col_wide;
    logic [AW-1:0] ofs_wide;
    assign row_wide = RW'(row_reg);
    assign col_wide = CW'(col_reg);
    assign ofs_wide = AW'(cur_reg);

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FIN) && out_free;

    always_comb begin
        res.pos_row       = row_wide[tcw_pkg::OROW_W-1:0];
        res.pos_col       = col_wide[tcw_pkg::OCOL_W-1:0];
        res.cursor_offset = ofs_wide[tcw_pkg::OFS_W-1:0];
        res.cell_char     = cchar_reg;
        res.cell_attr     = cattr_reg;
    end

    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        base_next     = base_reg;
        cur_next      = cur_reg;
        attr_next     = attr_reg;
        ptr_next      = ptr_reg;
        cp_valid_next = cp_valid_reg;
        cp_dst_next   = cp_dst_reg;
        rd_addr_next  = rd_addr_reg;
        cchar_next    = cchar_reg;
        cattr_next    = cattr_reg;
        ram_we        = 1'b0;
        ram_waddr     = ptr_reg;
        ram_wdata     = {attr_reg, tcw_pkg::SPACE_CODE};
        ram_re        = 1'b0;
        ram_raddr     = ptr_reg;

        unique case (state_reg)
            ST_CLR_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                ptr_next  = ptr_inc;
                if (ptr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cchar_next = '0;
                cattr_next = '0;
                state_next = ST_FIN;
                unique case (func_reg)
                    tcw_pkg::FUNC_PUT: begin
                        if (!is_nl) begin
                            ram_we    = 1'b1;
                            ram_waddr = cur_reg;
                            ram_wdata = {attr_reg, char_reg};
                        end
                        if (!do_nl) begin
                            col_next = col_reg + 1'b1;
                            cur_next = cur_reg + 1'b1;
                        end else begin
                            col_next = '0;
                            if (row_reg == LAST_ROW) begin
                                cur_next      = base_reg;
                                ptr_next      = COL_STEP;
                                cp_valid_next = 1'b0;
                                state_next    = ST_SCROLL;
                            end else begin
                                row_next  = row_reg + 1'b1;
                                base_next = base_reg + COL_STEP;
                                cur_next  = base_reg + COL_STEP;
                            end
                        end
                    end
                    tcw_pkg::FUNC_COLORS: begin
                        attr_next = {bg_reg, fg_reg};
                    end
                    tcw_pkg::FUNC_CLEAR: begin
                        attr_next  = tcw_pkg::CLEAR_ATTR;
                        row_next   = '0;
                        col_next   = '0;
                        base_next  = '0;
                        cur_next   = '0;
                        ptr_next   = '0;
                        state_next = ST_FILL;
                    end
                    tcw_pkg::FUNC_READ: begin
                        if (in_range) begin
                            rd_addr_next = rd_addr_calc;
                            state_next   = ST_RD_ISSUE;
                        end
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_SCROLL: begin
                // read one row ahead, write the cell fetched last cycle
                ram_re        = 1'b1;
                ram_we        = cp_valid_reg;
                ram_waddr     = cp_dst_reg;
                ram_wdata     = ram_rdata;
                cp_valid_next = 1'b1;
                cp_dst_next   = ptr_reg - COL_STEP;
                ptr_next      = ptr_inc;
                if (ptr_last) begin
                    state_next = ST_SCR_END;
                end
            end
            ST_SCR_END: begin
                ram_we        = cp_valid_reg;
                ram_waddr     = cp_dst_reg;
                ram_wdata     = ram_rdata;
                cp_valid_next = 1'b0;
                ptr_next      = LAST_ROW_BASE;
                state_next    = ST_FILL;
            end
            ST_FILL: begin
                ram_we   = 1'b1;
                ptr_next = ptr_inc;
                if (ptr_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_RD_ISSUE: begin
                ram_re     = 1'b1;
                ram_raddr  = rd_addr_reg;
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                cchar_next = ram_rdata[7:0];
                cattr_next = ram_rdata[15:8];
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR_INIT;
            row_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            cur_reg      <= '0;
            attr_reg     <= '0;
            ptr_reg      <= '0;
            cp_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            base_reg     <= base_next;
            cur_reg      <= cur_next;
            attr_reg     <= attr_next;
            ptr_reg      <= ptr_next;
            cp_valid_reg <= cp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_dst_reg  <= cp_dst_next;
        rd_addr_reg <= rd_addr_next;
        cchar_reg   <= cchar_next;
        cattr_reg   <= cattr_next;
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            char_reg <= s_char_code;
            fg_reg   <= s_fg_color;
            bg_reg   <= s_bg_color;
            rrow_reg <= s_read_row;
            rcol_reg <= s_read_col;
        end
    end

endmodule

@@ rtl/text_console_writer_core.sv @@
// Text console writer top level: sequencer, screen memory and result register.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | func, char_code, fg/bg_color, read_row/col
//  m_      | out       | m_valid / m_ready  | cursor_row/col/offset, cell_char/attr
//
// A character, a newline without scroll, set colors or an out-of-range read passes
// through the execute and finish states to m_valid; a cell read adds an issue and a
// wait state (registered memory read). The next item is taken once the finish state
// has handed its result to the output register. Scroll and clear sweep the screen
// memory cell by cell before m_valid. After reset a clearing pass zeroes the screen
// with s_ready low. One item in flight; a stalled m_ready holds the result; the next
// item is still taken meanwhile.
module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tcw_pkg::FUNC_W-1:0]    s_func,
    input  logic [tcw_pkg::CHAR_W-1:0]    s_char_code,
    input  logic [tcw_pkg::COLOR_W-1:0]   s_fg_color,
    input  logic [tcw_pkg::COLOR_W-1:0]   s_bg_color,
    input  logic [tcw_pkg::RROW_W-1:0]    s_read_row,
    input  logic [tcw_pkg::RCOL_W-1:0]    s_read_col,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tcw_pkg::OROW_W-1:0]    m_cursor_row,
    output logic [tcw_pkg::OCOL_W-1:0]    m_cursor_col,
    output logic [tcw_pkg::OFS_W-1:0]     m_cursor_offset,
    output logic [tcw_pkg::CHAR_W-1:0]    m_cell_char,
    output logic [7:0]                    m_cell_attr
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    logic                        out_free;
    logic                        res_valid;
    tcw_pkg::res_t               res;
    tcw_pkg::res_t               res_reg;
    logic                        m_valid_reg;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

    // The result register is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_char_code (s_char_code),
        .s_fg_color  (s_fg_color),
        .s_bg_color  (s_bg_color),
        .s_read_row  (s_read_row),
        .s_read_col  (s_read_col),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // Screen cells: character in bits 7..0, attribute in bits 15..8.
    tcw_screen_ram #(
        .DEPTH (CELLS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: parts the sequencer from a stalled consumer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cursor_row    = res_reg.pos_row;
    assign m_cursor_col    = res_reg.pos_col;
    assign m_cursor_offset = res_reg.cursor_offset;
    assign m_cell_char     = res_reg.cell_char;
    assign m_cell_attr     = res_reg.cell_attr;

endmodule

@@ rtl/tcw_checker.sv @@
// Port-level checker for the text console writer, bound to the top level.
`include "text_console_writer_core_assert.svh"

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [tcw_pkg::OROW_W-1:0]    m_cursor_row,
    input logic [tcw_pkg::OCOL_W-1:0]    m_cursor_col,
    input logic [tcw_pkg::OFS_W-1:0]     m_cursor_offset,
    input logic [tcw_pkg::CHAR_W-1:0]    m_cell_char,
    input logic [7:0]                    m_cell_attr
);

    // offset is checkable only when no output field is truncated
    localparam bit EXACT = (ROWS <= 32) && (COLUMNS <= 128) && (ROWS * COLUMNS <= 2048);

    `TCW_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_cursor_offset) && $stable(m_cell_char) && $stable(m_cell_attr), "stalled result changed")

    `TCW_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready high right after accept")

    `TCW_ASSERT_SAME(a_offset_consistent, m_valid && EXACT, (32'(m_cursor_col) < COLUMNS) && (m_cursor_offset == 11'(32'(m_cursor_row) * COLUMNS + 32'(m_cursor_col))), "cursor offset mismatch")

    `TCW_ASSERT_RESET(a_reset_quiet, !aresetn, !s_ready && !m_valid, "not quiet after reset")

endmodule

bind text_console_writer_core tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);

@@ bench/text_console_writer_core_tb.sv @@
// Self-checking testbench for the text console writer core.
`timescale 1ns / 100ps

module text_console_writer_core_tb;

    // Screen geometry of the instance under test (block defaults).
    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;

    // Stimulus sizing.
    localparam int RANDOM_ITEMS = 1500;

    // Receiver long hold-off: starts after this many results, lasts this long.
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 600;

    // Worst single waits, used to size the run limit.
    localparam int MAX_GAP   = 10;
    localparam int MAX_STALL = 16;
    localparam int SWEEP     = CELLS + 3;   // scroll or clear walks the whole screen

    // Quiet cycles after the last result, to catch any stray result.
    localparam int DRAIN_CYCLES = 64;

    // One console command as it crosses the s_ handshake.
    typedef struct packed {
        logic [tcw_pkg::FUNC_W-1:0]  func;
        logic [tcw_pkg::CHAR_W-1:0]  glyph;
        logic [tcw_pkg::COLOR_W-1:0] fg;
        logic [tcw_pkg::COLOR_W-1:0] bg;
        logic [tcw_pkg::RROW_W-1:0]  rrow;
        logic [tcw_pkg::RCOL_W-1:0]  rcol;
    } cmd_t;

    // ------------------------------------------------------------------
    // DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [tcw_pkg::FUNC_W-1:0]  s_func = tcw_pkg::FUNC_PUT;
    logic [tcw_pkg::CHAR_W-1:0]  s_char_code = '0;
    logic [tcw_pkg::COLOR_W-1:0] s_fg_color = '0;
    logic [tcw_pkg::COLOR_W-1:0] s_bg_color = '0;
    logic [tcw_pkg::RROW_W-1:0]  s_read_row = '0;
    logic [tcw_pkg::RCOL_W-1:0]  s_read_col = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [tcw_pkg::OROW_W-1:0]  m_cursor_row;
    logic [tcw_pkg::OCOL_W-1:0]  m_cursor_col;
    logic [tcw_pkg::OFS_W-1:0]   m_cursor_offset;
    logic [tcw_pkg::CHAR_W-1:0]  m_cell_char;
    logic [7:0]                  m_cell_attr;

    text_console_writer_core #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_char_code     (s_char_code),
        .s_fg_color      (s_fg_color),
        .s_bg_color      (s_bg_color),
        .s_read_row      (s_read_row),
        .s_read_col      (s_read_col),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_col    (m_cursor_col),
        .m_cursor_offset (m_cursor_offset),
        .m_cell_char     (m_cell_char),
        .m_cell_attr     (m_cell_attr)
    );

    // 12 ns clock.
    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow console: our own copy of the screen, cursor and attribute.
    // Reset state is an all-zero screen, cursor home, attribute zero.
    // ------------------------------------------------------------------
    logic [tcw_pkg::CELL_W-1:0] screen_img [CELLS];
    logic [tcw_pkg::OROW_W-1:0] row_now = '0;
    logic [tcw_pkg::OCOL_W-1:0] col_now = '0;
    logic [7:0]                 attr_now = '0;

    // Coverage-ish tallies for the closing summary.
    int glyph_count   = 0;
    int newline_count = 0;
    int wrap_count    = 0;
    int scroll_count  = 0;
    int color_count   = 0;
    int clear_count   = 0;
    int read_hits     = 0;
    int read_misses   = 0;

    initial begin
        foreach (screen_img[i]) screen_img[i] = '0;
    end

    // Move to column 0 of the next row; on the last row, scroll up one row
    // and blank the new bottom row in the current attribute.
    function automatic void cursor_newline();
        col_now = '0;
        if (int'(row_now) + 1 >= ROWS) begin
            for (int i = 0; i < CELLS - COLS; i++) screen_img[i] = screen_img[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
                screen_img[i] = {attr_now, tcw_pkg::SPACE_CODE};
            row_now = tcw_pkg::OROW_W'(ROWS - 1);
            scroll_count++;
        end else begin
            row_now = row_now + 1'b1;
        end
    endfunction

    // Apply one command to the shadow console and return the result it owes.
    function automatic tcw_pkg::res_t console_apply(cmd_t c);
        tcw_pkg::res_t r;
        logic [tcw_pkg::CELL_W-1:0] rd_cell;
        int ofs;
        r = '0;
        case (c.func)
            tcw_pkg::FUNC_PUT: begin
                if (c.glyph == tcw_pkg::NEWLINE_CODE) begin
                    newline_count++;
                    cursor_newline();
                end else begin
                    glyph_count++;
                    screen_img[int'(row_now) * COLS + int'(col_now)] = {attr_now, c.glyph};
                    if (int'(col_now) + 1 >= COLS) begin
                        // full row: the cursor wraps like a newline
                        wrap_count++;
                        cursor_newline();
                    end else begin
                        col_now = col_now + 1'b1;
                    end
                end
            end
            tcw_pkg::FUNC_COLORS: begin
                color_count++;
                attr_now = {c.bg, c.fg};
            end
            tcw_pkg::FUNC_CLEAR: begin
                clear_count++;
                attr_now = tcw_pkg::CLEAR_ATTR;
                foreach (screen_img[i])
                    screen_img[i] = {tcw_pkg::CLEAR_ATTR, tcw_pkg::SPACE_CODE};
                row_now = '0;
                col_now = '0;
            end
            default: begin
                // out-of-range reads return zeros and touch nothing
                if (int'(c.rrow) < ROWS && int'(c.rcol) < COLS) begin
                    read_hits++;
                    rd_cell = screen_img[int'(c.rrow) * COLS + int'(c.rcol)];
                    r.cell_char = rd_cell[7:0];
                    r.cell_attr = rd_cell[15:8];
                end else begin
                    read_misses++;
                end
            end
        endcase
        ofs = int'(row_now) * COLS + int'(col_now);
        r.pos_row       = row_now;
        r.pos_col       = col_now;
        r.cursor_offset = ofs[tcw_pkg::OFS_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus. Fields a command does not use carry random noise so that
    // every input bit toggles.
    // ------------------------------------------------------------------
    cmd_t stim_q [$];
    int   stim_total = 0;
    int   cycle_limit = 0;

    function automatic cmd_t scrambled_cmd();
        cmd_t c;
        c.func  = tcw_pkg::FUNC_PUT;
        c.glyph = tcw_pkg::CHAR_W'($urandom);
        c.fg    = tcw_pkg::COLOR_W'($urandom);
        c.bg    = tcw_pkg::COLOR_W'($urandom);
        c.rrow  = tcw_pkg::RROW_W'($urandom);
        c.rcol  = tcw_pkg::RCOL_W'($urandom);
        return c;
    endfunction

    function automatic void queue_put(logic [tcw_pkg::CHAR_W-1:0] ch);
        cmd_t c;
        c = scrambled_cmd();
        c.func  = tcw_pkg::FUNC_PUT;
        c.glyph = ch;
        stim_q.push_back(c);
    endfunction

    function automatic void queue_colors(logic [tcw_pkg::COLOR_W-1:0] fg,
                                         logic [tcw_pkg::COLOR_W-1:0] bg);
        cmd_t c;
        c = scrambled_cmd();
        c.func = tcw_pkg::FUNC_COLORS;
        c.fg   = fg;
        c.bg   = bg;
        stim_q.push_back(c);
    endfunction

    function automatic void queue_clear();
        cmd_t c;
        c = scrambled_cmd();
        c.func = tcw_pkg::FUNC_CLEAR;
        stim_q.push_back(c);
    endfunction

    function automatic void queue_read(int r, int col);
        cmd_t c;
        c = scrambled_cmd();
        c.func = tcw_pkg::FUNC_READ;
        c.rrow = tcw_pkg::RROW_W'(r);
        c.rcol = tcw_pkg::RCOL_W'(col);
        stim_q.push_back(c);
    endfunction

    // Mostly printable text; one in ten is any byte, newline included.
    function automatic logic [tcw_pkg::CHAR_W-1:0] pick_glyph();
        if ($urandom_range(0, 9) == 0) return tcw_pkg::CHAR_W'($urandom_range(0, 255));
        return tcw_pkg::CHAR_W'($urandom_range(32, 126));
    endfunction

    function automatic void build_stimulus();
        int scene;
        int len;
        int target;
        int sweeps;
        int puts;
        // Directed opening: reset contents, read bounds, color extremes,
        // byte extremes, newline, clear screen.
        queue_read(0, 0);
        queue_read(ROWS - 1, COLS - 1);
        queue_read(ROWS, 0);               // row just past the screen
        queue_read(0, COLS);               // column just past the screen
        queue_read(31, 127);               // all read bits set
        queue_colors(4'hF, 4'hF);
        queue_put(8'hFF);
        queue_colors(4'h0, 4'h0);
        queue_put(8'h00);
        queue_colors(4'hA, 4'h5);
        queue_put(8'h41);
        queue_put(tcw_pkg::NEWLINE_CODE);
        queue_read(0, 0);
        queue_read(0, 1);
        queue_read(0, 2);
        queue_read(1, 0);
        queue_clear();
        queue_read(0, 0);
        queue_read(ROWS - 1, COLS - 1);
        queue_put(8'h7E);
        queue_read(0, 0);

        // Random scenes: text lines (some long enough to wrap), newline
        // runs that push into scrolling, color changes, reads, rare clears.
        target = stim_q.size() + RANDOM_ITEMS;
        while (stim_q.size() < target) begin
            scene = $urandom_range(0, 99);
            if (scene < 55) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 170)
                                                  : $urandom_range(0, 60);
                for (int i = 0; i < len; i++) queue_put(pick_glyph());
                if ($urandom_range(0, 9) < 7) queue_put(tcw_pkg::NEWLINE_CODE);
            end else if (scene < 65) begin
                queue_colors(tcw_pkg::COLOR_W'($urandom), tcw_pkg::COLOR_W'($urandom));
            end else if (scene < 92) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 4) == 0)
                        queue_read($urandom_range(0, 31), $urandom_range(0, 127));
                    else
                        queue_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
                end
            end else if (scene < 95) begin
                queue_clear();
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) queue_put(tcw_pkg::NEWLINE_CODE);
            end
        end
        stim_total = stim_q.size();

        // Run limit: every newline and clear taken as a full sweep, one wrap
        // per 80 glyphs, plus the worst gap and stall on every item, the
        // post-reset clearing pass and the long hold-off; then four times over.
        sweeps = 0;
        puts = 0;
        foreach (stim_q[i]) begin
            if (stim_q[i].func == tcw_pkg::FUNC_CLEAR ||
                (stim_q[i].func == tcw_pkg::FUNC_PUT &&
                 stim_q[i].glyph == tcw_pkg::NEWLINE_CODE))
                sweeps++;
            else if (stim_q[i].func == tcw_pkg::FUNC_PUT)
                puts++;
        end
        sweeps += puts / COLS + 1;
        cycle_limit = 4 * (CELLS + HOLD_CYCLES + sweeps * SWEEP
                           + stim_total * (5 + MAX_GAP + MAX_STALL)) + 1000;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. Some
    // bursts are long so there are stretches with no idling at all.
    // ------------------------------------------------------------------
    logic s_took = 1'b0;       // an item was accepted at the last rising edge
    int   burst_left = 1;
    int   gap_left = 0;
    cmd_t next_cmd;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_took) begin
            // offered but not taken yet: hold valid and payload
        end else if (gap_left > 0) begin
            s_valid  <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (stim_q.size() > 0) begin
            next_cmd = stim_q.pop_front();
            s_valid     <= 1'b1;
            s_func      <= next_cmd.func;
            s_char_code <= next_cmd.glyph;
            s_fg_color  <= next_cmd.fg;
            s_bg_color  <= next_cmd.bg;
            s_read_row  <= next_cmd.rrow;
            s_read_col  <= next_cmd.rcol;
            if (burst_left <= 1) begin
                burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                          : $urandom_range(1, 12);
                gap_left   <= $urandom_range(1, MAX_GAP);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a 16-bit mask that is redrawn each lap,
    // a quarter of the laps fully open. Once, after HOLD_AT results, ready
    // stays low for HOLD_CYCLES so the block backs up and stalls s_ready
    // while the sender keeps offering.
    // ------------------------------------------------------------------
    int          result_count = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic [15:0] ready_mask = 16'hFFFF;
    logic [3:0]  rx_phase = '0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && result_count >= HOLD_AT) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else begin
            m_ready  <= ready_mask[rx_phase];
            rx_phase <= rx_phase + 1'b1;
            if (rx_phase == 4'hF)
                ready_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted item is run through the shadow console and
    // its result queued; every accepted result is checked against the
    // oldest queued one.
    // ------------------------------------------------------------------
    tcw_pkg::res_t expect_q [$];
    int            accepted_count = 0;
    int            fault_count = 0;

    task automatic log_fault(string what, tcw_pkg::res_t want, tcw_pkg::res_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s: exp row=%0d col=%0d ofs=%0d char=%02h attr=%02h,",
                     $realtime, what,
                     want.pos_row, want.pos_col, want.cursor_offset,
                     want.cell_char, want.cell_attr,
                     " got row=%0d col=%0d ofs=%0d char=%02h attr=%02h",
                     got.pos_row, got.pos_col, got.cursor_offset,
                     got.cell_char, got.cell_attr);
    endtask

    always @(posedge aclk) begin
        cmd_t          taken;
        tcw_pkg::res_t got;
        tcw_pkg::res_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                taken.func  = s_func;
                taken.glyph = s_char_code;
                taken.fg    = s_fg_color;
                taken.bg    = s_bg_color;
                taken.rrow  = s_read_row;
                taken.rcol  = s_read_col;
                expect_q.push_back(console_apply(taken));
                accepted_count++;
            end
            if (m_valid && m_ready) begin
                result_count++;
                got.pos_row       = m_cursor_row;
                got.pos_col       = m_cursor_col;
                got.cursor_offset = m_cursor_offset;
                got.cell_char     = m_cell_char;
                got.cell_attr     = m_cell_attr;
                if (expect_q.size() == 0) begin
                    log_fault("result with nothing pending", '0, got);
                end else begin
                    want = expect_q.pop_front();
                    if (got.pos_row !== want.pos_row ||
                        got.pos_col !== want.pos_col ||
                        got.cursor_offset !== want.cursor_offset ||
                        got.cell_char !== want.cell_char ||
                        got.cell_attr !== want.cell_attr)
                        log_fault("result mismatch", want, got);
                end
            end
        end
    end

    // Run limit: counts cycles and ends a hung run.
    int cycle_count = 0;

    initial begin
        do begin
            @(posedge aclk);
            cycle_count++;
        end while (cycle_count < cycle_limit);
        $display("timeout after %0d cycles: %0d of %0d items taken, %0d results pending",
                 cycle_count, accepted_count, stim_total, expect_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: build the stimulus, hold reset, wait for every item
    // to go in and every result to come back, then drain.
    // ------------------------------------------------------------------
    initial begin
        build_stimulus();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (!(accepted_count == stim_total && expect_q.size() == 0))
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items: %0d glyphs, %0d newlines, %0d wraps, %0d scrolls",
                 stim_total, glyph_count, newline_count, wrap_count, scroll_count);
        $display("  %0d color sets, %0d clears, %0d reads in range, %0d out of range; %0d faults",
                 color_count, clear_count, read_hits, read_misses, fault_count);
        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_core.sv
rtl/tcw_checker.sv
bench/text_console_writer_core_tb.sv
